/* hw/rtl/apm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_pkg
// Shared constants, codes and types of the autoscale point mapper.
// ----------------------------------------------------------------------------
package apm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W    = 16;              // signed Q4.12 sample
    localparam int SCR_W      = 12;              // screen coordinate
    localparam int ENTRY_W    = 2 * COORD_W;     // x low half, y high half
    localparam int DIFF_W     = COORD_W + 1;     // v - a, b - a
    localparam int SPAN_W     = SCR_W + 1;       // hi - lo
    localparam int PROD_W     = DIFF_W + SPAN_W; // (v - a) * (hi - lo)
    localparam int MAG_W      = PROD_W - 1;      // dividend magnitude
    localparam int DVS_W      = DIFF_W;          // divisor magnitude
    localparam int SUM_W      = PROD_W + 1;

    localparam int SCR_MAX    = (1 << SCR_W) - 1;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_END       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_X_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_X_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_Y_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_Y_HI = 3'd5;

    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] dividend;
        logic signed [DIFF_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] quotient;   // floored
    } div_rsp_t;

    // lo + q, clamped to the screen range
    function automatic logic [SCR_W-1:0] sat_screen(input logic [SCR_W-1:0] lo,
                                                     input logic signed [PROD_W-1:0] q);
        logic signed [SUM_W-1:0] sum;
        sum = $signed({{(SUM_W-SCR_W){1'b0}}, lo}) + SUM_W'(q);
        if (sum < 0) begin
            return '0;
        end else if (sum > SUM_W'(SCR_MAX)) begin
            return SCR_W'(SCR_MAX);
        end else begin
            return sum[SCR_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/autoscale_point_mapper_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autoscale_point_mapper_core
// Point store with running y extremes; reads map a point to screen space.
// ----------------------------------------------------------------------------
// Clear and load leave the block idle; it is ready again the next cycle.
// A read of a stored point raises m_valid after the RAM read, then per axis
// a multiply, a divider setup and a 29-bit divide (a zero span skips it),
// then the output register, which waits for an untaken result. A read past the
// count goes straight to output. The next item is taken once the result loads.
// Reset (aresetn, synchronous, active low) empties the store, restores defaults.
module autoscale_point_mapper_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [apm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [apm_pkg::COORD_W-1:0]            cfg_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_kind,
    input  logic signed [apm_pkg::COORD_W-1:0]     s_sample_x,
    input  logic signed [apm_pkg::COORD_W-1:0]     s_sample_y,
    input  logic [9:0]                             s_point_index,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [apm_pkg::SCR_W-1:0]              m_screen_x,
    output logic [apm_pkg::SCR_W-1:0]              m_screen_y,
    output logic                                   m_valid_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam int CW = apm_pkg::COORD_W;
    localparam int SW = apm_pkg::SCR_W;

    logic [2:0]                        state_reg;
    logic [apm_pkg::CNT_W-1:0]         count_reg;
    logic signed [CW-1:0]              y_min_reg;
    logic signed [CW-1:0]              y_max_reg;
    logic signed [CW-1:0]              x_start_reg;
    logic signed [CW-1:0]              x_end_reg;
    logic [SW-1:0]                     sx_lo_reg;
    logic [SW-1:0]                     sx_hi_reg;
    logic [SW-1:0]                     sy_lo_reg;
    logic [SW-1:0]                     sy_hi_reg;

    logic                              axis_reg;     // 0: x, 1: y
    logic signed [apm_pkg::PROD_W-1:0] prod_reg;
    logic signed [apm_pkg::DIFF_W-1:0] span_reg;
    logic [SW-1:0]                     lo_reg;
    logic [SW-1:0]                     res_x_reg;
    logic [SW-1:0]                     res_y_reg;
    logic                              res_ok_reg;

    logic                              m_valid_reg;
    logic [SW-1:0]                     m_x_reg;
    logic [SW-1:0]                     m_y_reg;
    logic                              m_ok_reg;

    logic                              in_xfer;
    logic                              cfg_xfer;
    logic                              store_full;
    logic                              load_ok;
    logic                              idx_ok;
    logic [31:0]                       idx_wide;
    logic [apm_pkg::ENTRY_W-1:0]       entry;

    logic signed [CW-1:0]              op_v;
    logic signed [CW-1:0]              op_a;
    logic signed [CW-1:0]              op_b;
    logic [SW-1:0]                     op_lo;
    logic [SW-1:0]                     op_hi;
    logic signed [apm_pkg::DIFF_W-1:0] diff_next;
    logic signed [apm_pkg::DIFF_W-1:0] span_next;
    logic signed [apm_pkg::SPAN_W-1:0] scr_span;
    logic signed [apm_pkg::PROD_W-1:0] prod_next;
    logic [SW-1:0]                     axis_res;
    logic                              axis_ready;

    apm_pkg::div_req_t                 div_req;
    apm_pkg::div_rsp_t                 div_rsp;

    assign cfg_ready  = 1'b1;
    assign cfg_xfer   = cfg_valid && cfg_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign in_xfer    = s_valid && s_ready;

    assign store_full = (count_reg == apm_pkg::CNT_W'(apm_pkg::MAX_POINTS));
    assign load_ok    = in_xfer && s_kind == apm_pkg::KIND_LOAD && !store_full;
    assign idx_wide   = 32'(s_point_index);
    assign idx_ok     = idx_wide < 32'(count_reg);

    apm_ram #(
        .WIDTH (apm_pkg::ENTRY_W),
        .DEPTH (apm_pkg::MAX_POINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (load_ok),
        .waddr (count_reg[apm_pkg::IDX_W-1:0]),
        .wdata ({s_sample_y, s_sample_x}),
        .re    (in_xfer && s_kind == apm_pkg::KIND_READ),
        .raddr (idx_wide[apm_pkg::IDX_W-1:0]),
        .rdata (entry)
    );

    // operand select for the current axis
    always_comb begin
        if (axis_reg) begin
            op_v  = $signed(entry[apm_pkg::ENTRY_W-1:CW]);
            op_a  = y_min_reg;
            op_b  = y_max_reg;
            op_lo = sy_lo_reg;
            op_hi = sy_hi_reg;
        end else begin
            op_v  = $signed(entry[CW-1:0]);
            op_a  = x_start_reg;
            op_b  = x_end_reg;
            op_lo = sx_lo_reg;
            op_hi = sx_hi_reg;
        end
    end

    assign diff_next = apm_pkg::DIFF_W'(op_v) - apm_pkg::DIFF_W'(op_a);
    assign span_next = apm_pkg::DIFF_W'(op_b) - apm_pkg::DIFF_W'(op_a);
    assign scr_span  = $signed({1'b0, op_hi}) - $signed({1'b0, op_lo});
    assign prod_next = apm_pkg::PROD_W'(diff_next) * apm_pkg::PROD_W'(scr_span);

    assign div_req.start    = (state_reg == ST_START) && (span_reg != '0);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = span_reg;

    apm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // zero span maps to the low bound without a divide
    always_comb begin
        axis_ready = 1'b0;
        axis_res   = lo_reg;
        case (state_reg)
            ST_START: begin
                axis_ready = (span_reg == '0);
                axis_res   = lo_reg;
            end
            ST_DIV: begin
                axis_ready = div_rsp.done;
                axis_res   = apm_pkg::sat_screen(lo_reg, div_rsp.quotient);
            end
            default: begin
                axis_ready = 1'b0;
                axis_res   = lo_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            y_min_reg   <= '0;
            y_max_reg   <= '0;
            x_start_reg <= '0;
            x_end_reg   <= 16'sd25736;
            sx_lo_reg   <= '0;
            sx_hi_reg   <= 12'd500;
            sy_lo_reg   <= '0;
            sy_hi_reg   <= 12'd500;
            m_valid_reg <= 1'b0;
            axis_reg    <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                case (cfg_index)
                    apm_pkg::CFG_X_START:     x_start_reg <= $signed(cfg_data);
                    apm_pkg::CFG_X_END:       x_end_reg   <= $signed(cfg_data);
                    apm_pkg::CFG_SCREEN_X_LO: sx_lo_reg   <= cfg_data[SW-1:0];
                    apm_pkg::CFG_SCREEN_X_HI: sx_hi_reg   <= cfg_data[SW-1:0];
                    apm_pkg::CFG_SCREEN_Y_LO: sy_lo_reg   <= cfg_data[SW-1:0];
                    apm_pkg::CFG_SCREEN_Y_HI: sy_hi_reg   <= cfg_data[SW-1:0];
                    default: ;
                endcase
            end

            // in ST_OUT the output register is reloaded below instead
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        case (s_kind)
                            apm_pkg::KIND_CLEAR: begin
                                count_reg <= '0;
                                y_min_reg <= '0;
                                y_max_reg <= '0;
                            end
                            apm_pkg::KIND_LOAD: begin
                                if (!store_full) begin
                                    count_reg <= count_reg + 1'b1;
                                    if (count_reg == '0) begin
                                        y_min_reg <= s_sample_y;
                                        y_max_reg <= s_sample_y;
                                    end else begin
                                        if (s_sample_y < y_min_reg) begin
                                            y_min_reg <= s_sample_y;
                                        end
                                        if (s_sample_y > y_max_reg) begin
                                            y_max_reg <= s_sample_y;
                                        end
                                    end
                                end
                            end
                            apm_pkg::KIND_READ: begin
                                axis_reg  <= 1'b0;
                                state_reg <= idx_ok ? ST_RD : ST_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RD: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_START;
                end
                ST_START: begin
                    if (axis_ready) begin
                        state_reg <= axis_reg ? ST_OUT : ST_MUL;
                        axis_reg  <= 1'b1;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (axis_ready) begin
                        state_reg <= axis_reg ? ST_OUT : ST_MUL;
                        axis_reg  <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
            span_reg <= span_next;
            lo_reg   <= op_lo;
        end

        if (in_xfer && s_kind == apm_pkg::KIND_READ) begin
            res_ok_reg <= idx_ok;
            res_x_reg  <= '0;
            res_y_reg  <= '0;
        end else if (axis_ready) begin
            if (axis_reg) begin
                res_y_reg <= axis_res;
            end else begin
                res_x_reg <= axis_res;
            end
        end

        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_x_reg  <= res_x_reg;
            m_y_reg  <= res_y_reg;
            m_ok_reg <= res_ok_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_screen_x  = m_x_reg;
    assign m_screen_y  = m_y_reg;
    assign m_valid_res = m_ok_reg;

endmodule

/* hw/rtl/apm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/apm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_div
// Radix-2 restoring divider, one quotient bit per cycle, floored result.
// ----------------------------------------------------------------------------
module apm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  apm_pkg::div_req_t req,
    output apm_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(apm_pkg::MAG_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(apm_pkg::MAG_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [apm_pkg::MAG_W-1:0]     quo_reg;
    logic [apm_pkg::DVS_W-1:0]     rem_reg;
    logic [apm_pkg::DVS_W-1:0]     dvs_reg;
    logic                          neg_reg;

    logic [apm_pkg::PROD_W-1:0]    dvd_abs;
    logic [apm_pkg::DIFF_W-1:0]    dvs_abs;
    logic [apm_pkg::DVS_W:0]       shifted;
    logic [apm_pkg::DVS_W+1:0]     trial;
    logic [apm_pkg::DVS_W-1:0]     rem_next;
    logic [apm_pkg::MAG_W-1:0]     quo_next;
    logic [apm_pkg::PROD_W-1:0]    qadj;

    assign dvd_abs = req.dividend[apm_pkg::PROD_W-1] ? apm_pkg::PROD_W'(-req.dividend)
                                                     : apm_pkg::PROD_W'(req.dividend);
    assign dvs_abs = req.divisor[apm_pkg::DIFF_W-1] ? apm_pkg::DIFF_W'(-req.divisor)
                                                    : apm_pkg::DIFF_W'(req.divisor);

    assign shifted  = {rem_reg, quo_reg[apm_pkg::MAG_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign rem_next = trial[apm_pkg::DVS_W+1] ? shifted[apm_pkg::DVS_W-1:0]
                                              : trial[apm_pkg::DVS_W-1:0];
    assign quo_next = {quo_reg[apm_pkg::MAG_W-2:0], ~trial[apm_pkg::DVS_W+1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= dvd_abs[apm_pkg::MAG_W-1:0];
            dvs_reg  <= dvs_abs;
            neg_reg  <= req.dividend[apm_pkg::PROD_W-1] ^ req.divisor[apm_pkg::DIFF_W-1];
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    // floor: a negative quotient with a remainder rounds one further down
    assign qadj = {1'b0, quo_reg} + apm_pkg::PROD_W'(neg_reg && (rem_reg != '0));

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? $signed(-qadj) : $signed(qadj);

endmodule
